[src/nqbe_pkg.sv]
package nqbe_pkg;

   // board size register
   localparam int BOARD_W = 4;
   localparam logic [BOARD_W-1:0] BOARD_RESET = 4'd8;

   // packed result: one nibble per row
   localparam int FIELD_W = 4;
   localparam int COLS_W = 32;
   localparam int OUT_ROWS = COLS_W / FIELD_W;

   // controller to datapath
   typedef struct packed {
      logic clear;   // drop search state, start from the first placement
      logic step;    // run one search step
      logic empty;   // answer with no placement
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found;      // this step completes a placement
      logic exhausted;  // this step ends the search
      logic done;       // search already exhausted
   } sts_type;

endpackage

[src/nqbe_req_if.sv]
interface nqbe_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

[src/nqbe_rsp_if.sv]
interface nqbe_rsp_if import nqbe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic [COLS_W-1:0] queen_columns;

   modport source (output valid, output found, output queen_columns, input ready);
   modport sink (input valid, input found, input queen_columns, output ready);
endinterface

[src/nqbe_ctrl.sv]
module nqbe_ctrl import nqbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_restart,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_RESP   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.clear = req_restart;
               if (!req_restart && sts.done) begin
                  cmd.empty = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (sts.found || sts.exhausted) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

`ifndef NO_ASSERTIONS
   // a search never starts without an accepted word
   a_search_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) && !$past(state_ff == ST_SEARCH) |->
         $past(req_valid && req_ready))
      else $error("search entered without a request");

   // a response follows a finished step or an empty answer only
   a_resp_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) ##1 (state_ff == ST_RESP) |->
         $past(cmd.empty))
      else $error("response from idle without empty command");

   a_step_only_searching: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !cmd.clear && !cmd.empty)
      else $error("step issued together with another command");
`endif

endmodule

[src/nqbe_dpath.sv]
module nqbe_dpath import nqbe_pkg::*; #(
   parameter int MAX_N = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [BOARD_W-1:0] csr_wdata,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               rsp_found,
   output logic [COLS_W-1:0]  rsp_queen_columns
);

   localparam int CW = $clog2(MAX_N + 1);
   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DL = 2 * MAX_N - 1;
   localparam int PR = (MAX_N < OUT_ROWS) ? MAX_N : OUT_ROWS;

   logic [BOARD_W-1:0] board_ff, board_in;
   logic [CW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [MAX_N-1:0]   col_taken_ff, col_taken_in;
   logic [DL-1:0]      diag_ff, diag_in;
   logic [DL-1:0]      anti_ff, anti_in;
   logic               done_ff, done_in;
   logic               found_ff, found_in;
   logic [CW-1:0]      rows_ff [MAX_N];

   logic [CW-1:0]      n_eff;
   logic               place_go;
   logic [CW-1:0]      prow;
   logic [CW-1:0]      pcol;
   logic [CW-1:0]      fr, fc;
   logic [CW:0]        di, ai;
   logic [MAX_N-1:0]   cmask;
   logic [DL-1:0]      dmask, amask;
   logic               hit;
   logic               last_row;
   logic               row_write;
   logic [COLS_W-1:0]  cols;
   logic [CW+FIELD_W-1:0] ext;

   // board size saturates to the largest supported board
   assign n_eff = (int'(board_ff) > MAX_N) ? CW'(MAX_N) : CW'(board_ff);

   assign place_go = (row_ff < n_eff) && (col_ff < n_eff);
   assign prow     = row_ff - CW'(1);
   assign pcol     = rows_ff[prow[AW-1:0]];

   // one occupancy unit: tests and places at the candidate, or lifts the previous queen
   assign fr = place_go ? row_ff : prow;
   assign fc = place_go ? col_ff : pcol;
   assign di = {1'b0, fr} + {1'b0, n_eff} - (CW+1)'(1) - {1'b0, fc};
   assign ai = {1'b0, fr} + {1'b0, fc};

   assign cmask = MAX_N'(1) << fc;
   assign dmask = DL'(1) << di;
   assign amask = DL'(1) << ai;

   assign hit = (|(col_taken_ff & cmask)) | (|(diag_ff & dmask)) | (|(anti_ff & amask));
   assign last_row = ({1'b0, row_ff} + (CW+1)'(1)) == {1'b0, n_eff};

   assign sts = '{
      found:     place_go && !hit && last_row,
      exhausted: !place_go && ((row_ff == '0) || (row_ff > n_eff)),
      done:      done_ff
   };

   assign row_write = cmd.step && place_go && !hit;

   always_comb begin
      board_in     = board_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      col_taken_in = col_taken_ff;
      diag_in      = diag_ff;
      anti_in      = anti_ff;
      done_in      = done_ff;
      found_in     = found_ff;
      if (csr_we || cmd.clear) begin
         if (csr_we) begin
            board_in = csr_wdata;
         end
         row_in       = '0;
         col_in       = '0;
         col_taken_in = '0;
         diag_in      = '0;
         anti_in      = '0;
         done_in      = 1'b0;
      end else if (cmd.step) begin
         if (place_go) begin
            if (hit) begin
               col_in = col_ff + CW'(1);
            end else begin
               col_taken_in = col_taken_ff ^ cmask;
               diag_in      = diag_ff ^ dmask;
               anti_in      = anti_ff ^ amask;
               row_in       = row_ff + CW'(1);
               col_in       = '0;
               found_in     = last_row;
            end
         end else if (sts.exhausted) begin
            done_in  = 1'b1;
            found_in = 1'b0;
         end else begin
            // backtrack: lift the queen above and resume past its column
            col_taken_in = col_taken_ff ^ cmask;
            diag_in      = diag_ff ^ dmask;
            anti_in      = anti_ff ^ amask;
            row_in       = prow;
            col_in       = pcol + CW'(1);
         end
      end
      if (cmd.empty) begin
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff     <= BOARD_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         col_taken_ff <= '0;
         diag_ff      <= '0;
         anti_ff      <= '0;
         done_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         board_ff     <= board_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         col_taken_ff <= col_taken_in;
         diag_ff      <= diag_in;
         anti_ff      <= anti_in;
         done_ff      <= done_in;
         found_ff     <= found_in;
      end
   end

   // placed column per row
   always_ff @(posedge clock) begin
      if (row_write) begin
         rows_ff[row_ff[AW-1:0]] <= col_ff;
      end
   end

   always_comb begin
      cols = '0;
      ext  = '0;
      for (int r = 0; r < PR; r++) begin
         ext = {{FIELD_W{1'b0}}, rows_ff[r]};
         if (r < int'(n_eff)) begin
            cols[FIELD_W*r +: FIELD_W] = ext[FIELD_W-1:0];
         end
      end
   end

   assign rsp_found         = found_ff;
   assign rsp_queen_columns = found_ff ? cols : '0;

`ifndef NO_ASSERTIONS
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= n_eff)
      else $error("row count beyond board size");

   a_col_count: assert property (@(posedge clock) disable iff (reset)
      $countones(col_taken_ff) == int'(row_ff))
      else $error("column occupancy out of step with placed rows");

   a_diag_count: assert property (@(posedge clock) disable iff (reset)
      ($countones(diag_ff) == int'(row_ff)) && ($countones(anti_ff) == int'(row_ff)))
      else $error("diagonal occupancy out of step with placed rows");

   a_found_full: assert property (@(posedge clock) disable iff (reset)
      cmd.step && sts.found && !csr_we |=> found_ff && (row_ff == n_eff))
      else $error("solution reported on a partial board");
`endif

endmodule

[src/n_queens_backtrack_enumerator_unit.sv]
// channel   dir  handshake            word
// req_ch    in   valid/ready          restart
// rsp_ch    out  valid/ready          found, queen_columns[31:0]
// csr       in   csr_we (no ready)    csr_wdata[3:0] = board_size
//
// one request at a time: accepted in idle, then one search step per cycle
// (one column test, one placement or one backtrack), then the response word;
// a request without restart after exhaustion skips the search and answers empty
// the single occupancy unit (column, diagonal, anti-diagonal masks) sets the step rate
// reset: board_size = 8, search cleared; a csr write also clears the search
// rsp held while rsp_ch.ready is low; req_ch.ready stays low until it is taken
module n_queens_backtrack_enumerator_unit import nqbe_pkg::*; #(
   parameter int MAX_N = 8
) (
   input logic               clock,
   input logic               reset,
   nqbe_req_if.sink          req_ch,
   nqbe_rsp_if.source        rsp_ch,
   input logic               csr_we,
   input logic [BOARD_W-1:0] csr_wdata
);

   cmd_type cmd;   // controller commands
   sts_type sts;   // datapath status

   // sequencing: idle, search, respond
   nqbe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   // search state, occupancy masks, placed columns and result
   nqbe_dpath #(
      .MAX_N (MAX_N)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_found         (rsp_ch.found),
      .rsp_queen_columns (rsp_ch.queen_columns)
   );

endmodule

[tb/nqbe_tb_pkg.sv]
`timescale 1ns / 100ps

package nqbe_tb_pkg;
   import nqbe_pkg::*;

   localparam int MAX_ROWS = 8;

   typedef struct {
      bit              found;
      bit [COLS_W-1:0] queen_columns;
   } placement_type;

   class queens_scoreboard;
      bit [BOARD_W-1:0] board_size;
      bit [3:0]         col_at [MAX_ROWS];
      int unsigned      cur_row;
      bit [15:0]        col_mask;
      bit [15:0]        diag_mask;
      bit [15:0]        anti_mask;
      bit               exhausted;
      placement_type    pending_placements [$];
      int               errors;

      function new();
         board_size = BOARD_RESET;
         errors = 0;
         clear_search();
      endfunction

      function void clear_search();
         foreach (col_at[i]) col_at[i] = '0;
         cur_row = 0;
         col_mask = '0;
         diag_mask = '0;
         anti_mask = '0;
         exhausted = 1'b0;
      endfunction

      // a csr write also drops the search
      function void set_board(bit [BOARD_W-1:0] value);
         board_size = value;
         clear_search();
      endfunction

      function void flip_queen(int unsigned r, int unsigned c, int unsigned n);
         col_mask[c] = ~col_mask[c];
         diag_mask[r + n - 1 - c] = ~diag_mask[r + n - 1 - c];
         anti_mask[r + c] = ~anti_mask[r + c];
      endfunction

      // depth-first search up to the next full placement or to exhaustion
      function bit next_placement(int unsigned n);
         int unsigned r;
         int unsigned c;
         int unsigned pr;
         int unsigned pc;
         while (1) begin
            r = cur_row;
            if (r < n) begin
               c = 32'(col_at[r]);
               while (c < n && (col_mask[c] || diag_mask[r + n - 1 - c] || anti_mask[r + c]))
                  c++;
               if (c < n) begin
                  col_at[r] = 4'(c);
                  flip_queen(r, c, n);
                  cur_row = r + 1;
                  if (r + 1 == n) return 1'b1;
                  col_at[r + 1] = '0;
                  continue;
               end
            end
            if (r == 0 || r > n) begin
               exhausted = 1'b1;
               return 1'b0;
            end
            pr = r - 1;
            pc = 32'(col_at[pr]);
            flip_queen(pr, pc, n);
            col_at[pr] = 4'(pc + 1);
            cur_row = pr;
         end
      endfunction

      function bit note_request(bit restart);
         int unsigned   n;
         placement_type word;
         n = (board_size > MAX_ROWS) ? MAX_ROWS : 32'(board_size);
         word.found = 1'b0;
         word.queen_columns = '0;
         if (restart) clear_search();
         if (!exhausted) begin
            word.found = next_placement(n);
            if (word.found)
               for (int unsigned r = 0; r < n && r < OUT_ROWS; r++)
                  word.queen_columns[FIELD_W*r +: FIELD_W] = col_at[r];
         end
         pending_placements = {pending_placements, word};
         return word.found;
      endfunction

      function void check_response(bit found, bit [COLS_W-1:0] queen_columns);
         placement_type want;
         if (pending_placements.size() == 0) begin
            $error("unexpected response word: found %0d, queen_columns %h",
                   found, queen_columns);
            errors++;
            return;
         end
         want = pending_placements.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
         end
         if (queen_columns !== want.queen_columns) begin
            $error("queen_columns: expected %h, actual %h", want.queen_columns, queen_columns);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_placements.size();
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import nqbe_pkg::*;
   import nqbe_tb_pkg::*;

   // cycles with no handshake before giving up; a board of 8 needs well under
   // two thousand search steps between two placements, plus stalls
   localparam int QUIET_LIMIT = 20000;
   localparam int TARGET_WORDS = 1700;
   localparam int CALM_WORDS = 300;

   logic clock;
   logic reset;
   logic csr_we;
   logic [BOARD_W-1:0] csr_wdata;

   nqbe_req_if req_ch ();
   nqbe_rsp_if rsp_ch ();

   n_queens_backtrack_enumerator_unit #(
      .MAX_N(MAX_ROWS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   queens_scoreboard sb = new();

   bit calm;            // no idling on either side while set
   int words_sent;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls about 29 percent of the time unless calm
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 29);
   end

   // response checker and watchdog: values sampled at the edge are pre-edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.found, rsp_ch.queen_columns);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** n_queens_backtrack_enumerator_unit: FAILED **");
         $finish;
      end
   end

   // one request word; returns whether a placement is predicted for it
   task automatic send_word(input bit restart, output bit found);
      while (!calm && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // valid stays high here; the next call or a drain decides
      found = sb.note_request(restart);
      words_sent++;
   endtask

   // hold off the sender until every response is back
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // board size change only while the block sits idle
   task automatic write_board(input bit [BOARD_W-1:0] value);
      wait_drain();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_board(value);
   endtask

   // start with a random restart flag, walk the placements to exhaustion and a little past it;
   // some runs are cut short, some get stray restarts in the middle
   task automatic run_sequence();
      bit found;
      bit noisy;
      int extra;
      int cut;
      int count;
      noisy = ($urandom_range(99) < 30);
      cut = ($urandom_range(99) < 20) ? $urandom_range(1, 30) : 100000;
      extra = $urandom_range(0, 2);
      send_word(1'($urandom_range(1)), found);
      count = 1;
      while ((found || extra > 0) && count < cut) begin
         if (!found) extra--;
         send_word(noisy && ($urandom_range(99) < 8), found);
         count++;
         if ($urandom_range(99) < 2) wait_drain();
      end
   endtask

   // mostly mid sizes, sometimes the full board, a few extremes
   function automatic bit [BOARD_W-1:0] pick_board();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return BOARD_W'($urandom_range(0, 3));
      if (roll < 14) return BOARD_W'($urandom_range(9, 15));
      if (roll < 26) return BOARD_W'(8);
      return BOARD_W'($urandom_range(4, 7));
   endfunction

   initial begin
      bit found;
      // known values on every driven input from time zero
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.restart <= 1'b0;
      calm = 1'b0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset board of 8, first word without a restart
      send_word(1'b0, found);
      send_word(1'b1, found);
      send_word(1'b0, found);
      send_word(1'b0, found);

      // empty board: nothing ever found, restart or not
      write_board(4'd0);
      send_word(1'b0, found);
      send_word(1'b1, found);

      // single square: one placement, then exhausted and sticky
      write_board(4'd1);
      send_word(1'b0, found);
      send_word(1'b0, found);
      send_word(1'b0, found);
      send_word(1'b1, found);

      // boards with no placement at all
      write_board(4'd2);
      send_word(1'b0, found);
      write_board(4'd3);
      send_word(1'b1, found);

      // oversized board saturates to the full one
      write_board(4'd15);
      send_word(1'b0, found);
      send_word(1'b0, found);

      // board of 4: both placements then exhaustion
      write_board(4'd4);
      send_word(1'b0, found);
      send_word(1'b0, found);
      send_word(1'b0, found);

      // size written mid-search restarts the walk
      write_board(4'd5);
      send_word(1'b0, found);
      send_word(1'b0, found);
      write_board(4'd5);
      send_word(1'b0, found);

      // random phases; the first stretch runs with no idling anywhere
      calm = 1'b1;
      while (words_sent < TARGET_WORDS) begin
         if (calm && words_sent >= CALM_WORDS) calm = 1'b0;
         write_board(pick_board());
         repeat ($urandom_range(1, 2)) run_sequence();
      end

      wait_drain();
      repeat (40) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d response words never arrived", sb.outstanding());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("** n_queens_backtrack_enumerator_unit: PASSED **");
      end else begin
         $display("** n_queens_backtrack_enumerator_unit: FAILED **");
      end
      $finish;
   end

endmodule
